@@ src/laser_vector_byte_parser_core_macros.svh @@
// Assertion helpers for the laser vector byte parser.
// Each macro expects clk_i and rst_ni to exist in the using module.
`ifndef LASER_VECTOR_BYTE_PARSER_CORE_MACROS_SVH
`define LASER_VECTOR_BYTE_PARSER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define LVBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next one.
`define LVBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lvbp_pkg.sv @@
// ----------------------------------------------------------------------------
// lvbp_pkg
// Shared types of the laser vector byte parser: result item and the bundle
// of results one input byte produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lvbp_pkg;

  localparam int unsigned CoordW = 8;

  // One result item
  typedef struct packed {
    logic              kind;      // 0 point, 1 line end
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              first_in_line;
    logic              last_of_run;
  } result_t;

  // Results caused by one accepted byte (0, 1 or 2 of them)
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } gen_t;

  localparam logic KindPoint   = 1'b0;
  localparam logic KindLineEnd = 1'b1;

  // Line end marker, last flag filled in by the producer
  localparam result_t LineEndRes = '{kind: KindLineEnd, point_x: '0, point_y: '0,
                                     first_in_line: 1'b0, last_of_run: 1'b0};

endpackage

`default_nettype wire

@@ src/laser_vector_byte_parser_core.sv @@
// ----------------------------------------------------------------------------
// laser_vector_byte_parser_core
// Laser vector file parser: bytes in, drawn points and line ends out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one file byte per request; tuser high marks the first byte
//   of a file (low count byte) and restarts the parser, closing an open line.
//   Master stream: one point or line end per request; tlast marks the final
//   result caused by one input byte. A byte may cause zero, one or two results.
//   An accepted byte's results are written into the result queue in order.
//   Throughput: one byte per cycle while s_axis_tready is high; results leave
//   at one per cycle while m_axis_tready is high. The limit is the four-entry
//   result queue, which accepts a byte only with room for two.
//   Receiver stall: results wait in the queue; once it holds more than two,
//   s_axis_tready drops until the receiver takes results again.
//   Reset: the parser waits for a file start, beam off, no line open, and the
//   result queue is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "laser_vector_byte_parser_core_macros.svh"

module laser_vector_byte_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] point_x, [15:8] point_y,
                                           // [16] first_in_line, rest zero
  output logic             m_axis_tuser,   // [0] kind
  output logic             m_axis_tlast    // last_of_run
);

  import lvbp_pkg::*;

  localparam int unsigned QDepth = 4;

  logic       req_acc;
  logic       pop;
  gen_t       gen;
  result_t    head;
  result_t    queue_q [QDepth];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] count_q, count_d;

  // Input handshake: room for the worst case of two results
  assign s_axis_tready = (count_q <= 3'd2);
  assign req_acc       = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  lvbp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_acc),
    .data_byte_i  (s_axis_tdata),
    .frame_start_i(s_axis_tuser),
    .gen_o        (gen)
  );

  // Result queue pointers
  always_comb begin
    wr_d    = wr_q + gen.cnt;
    rd_d    = rd_q + {1'b0, pop};
    count_d = count_q + {1'b0, gen.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Result queue storage, up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (gen.cnt != 2'd0) begin
      queue_q[wr_q] <= gen.r0;
    end
    if (gen.cnt == 2'd2) begin
      queue_q[wr_q + 2'd1] <= gen.r1;
    end
  end

  // Output side
  assign head          = queue_q[rd_q];
  assign m_axis_tvalid = (count_q != 3'd0);
  assign m_axis_tdata  = {7'd0, head.first_in_line, head.point_y, head.point_x};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last_of_run;

  // Checks
  `LVBP_ASSERT(a_count_bound, count_q <= 3'd4, "result queue overflow")
  `LVBP_ASSERT(a_no_gen_unless_acc, (gen.cnt == 2'd0) || req_acc, "result without request")
  `LVBP_ASSERT(a_pair_order, (gen.cnt != 2'd2) || (gen.r1.last_of_run && !gen.r0.last_of_run),
               "two results with wrong last flags")
  `LVBP_ASSERT_NEXT(a_result_shown, gen.cnt != 2'd0, m_axis_tvalid,
                    "queued result not offered")

endmodule

`default_nettype wire

@@ src/lvbp_parser.sv @@
// ----------------------------------------------------------------------------
// lvbp_parser
// File byte parser: count, header skip, x/y pairs, beam control and line
// tracking. Produces up to two results for each accepted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lvbp_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         req_valid_i,   // a byte request is taken this cycle
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         frame_start_i,
  output lvbp_pkg::gen_t    gen_o
);

  import lvbp_pkg::*;

  // Parser phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_CNTHI = 3'd1;
  localparam logic [2:0] PH_HDRA  = 3'd2;
  localparam logic [2:0] PH_HDRB  = 3'd3;
  localparam logic [2:0] PH_PX    = 3'd4;
  localparam logic [2:0] PH_PY    = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] pairs_left_q, pairs_left_d;
  logic [7:0]  count_low_q, count_low_d;
  logic [7:0]  x_hold_q, x_hold_d;
  logic        beam_on_q, beam_on_d;
  logic        line_open_q, line_open_d;
  logic [7:0]  last_x_q, last_x_d;
  logic [7:0]  last_y_q, last_y_d;

  // Next state and results
  always_comb begin
    logic [16:0] cnt_inc;
    logic [7:0]  y_inv;
    logic        is_cmd;
    logic        pt_emit;
    logic        end_emit;
    logic        open_v;
    result_t     pt;
    result_t     le;

    phase_d      = phase_q;
    pairs_left_d = pairs_left_q;
    count_low_d  = count_low_q;
    x_hold_d     = x_hold_q;
    beam_on_d    = beam_on_q;
    line_open_d  = line_open_q;
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    gen_o        = '0;

    cnt_inc  = {1'b0, data_byte_i, count_low_q} + 17'd1;
    y_inv    = 8'd255 - data_byte_i;
    is_cmd   = (x_hold_q == 8'd255) && (data_byte_i inside {8'd254, 8'd255});
    pt_emit  = 1'b0;
    end_emit = 1'b0;
    open_v   = line_open_q;
    pt       = '{kind: KindPoint, point_x: x_hold_q, point_y: y_inv,
                 first_in_line: !line_open_q, last_of_run: 1'b0};
    le       = LineEndRes;

    if (req_valid_i) begin
      if (frame_start_i) begin
        // restart; close a line left open by the previous file
        if (line_open_q) begin
          le.last_of_run = 1'b1;
          gen_o.cnt      = 2'd1;
          gen_o.r0       = le;
        end
        line_open_d = 1'b0;
        beam_on_d   = 1'b0;
        last_x_d    = '0;
        last_y_d    = '0;
        x_hold_d    = '0;
        count_low_d = data_byte_i;
        phase_d     = PH_CNTHI;
      end else begin
        case (phase_q)
          PH_CNTHI: begin
            pairs_left_d = cnt_inc[16:1];
            phase_d      = PH_HDRA;
          end
          PH_HDRA: phase_d = PH_HDRB;
          PH_HDRB: phase_d = (pairs_left_q == '0) ? PH_DONE : PH_PX;
          PH_PX: begin
            x_hold_d = data_byte_i;
            phase_d  = PH_PY;
          end
          PH_PY: begin
            if (is_cmd) begin
              beam_on_d = (data_byte_i == 8'd255);
            end else if (beam_on_q) begin
              // drop a repeat of the previous point of the same line
              if (!line_open_q || last_x_q != x_hold_q || last_y_q != y_inv) begin
                pt_emit  = 1'b1;
                open_v   = 1'b1;
                last_x_d = x_hold_q;
                last_y_d = y_inv;
              end
            end else if (line_open_q) begin
              end_emit = 1'b1;
              open_v   = 1'b0;
            end
            pairs_left_d = pairs_left_q - 16'd1;
            if (pairs_left_q == 16'd1) begin
              if (open_v) begin
                end_emit = 1'b1;
                open_v   = 1'b0;
              end
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_PX;
            end
            line_open_d = open_v;

            // pack results in order, flag the final one
            le.last_of_run = 1'b1;
            if (pt_emit && end_emit) begin
              gen_o.cnt = 2'd2;
              gen_o.r0  = pt;
              gen_o.r1  = le;
            end else if (pt_emit) begin
              pt.last_of_run = 1'b1;
              gen_o.cnt      = 2'd1;
              gen_o.r0       = pt;
            end else if (end_emit) begin
              gen_o.cnt = 2'd1;
              gen_o.r0  = le;
            end
          end
          default: phase_d = (phase_q == PH_DONE) ? PH_DONE : PH_IDLE;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      pairs_left_q <= '0;
      count_low_q  <= '0;
      x_hold_q     <= '0;
      beam_on_q    <= 1'b0;
      line_open_q  <= 1'b0;
      last_x_q     <= '0;
      last_y_q     <= '0;
    end else begin
      phase_q      <= phase_d;
      pairs_left_q <= pairs_left_d;
      count_low_q  <= count_low_d;
      x_hold_q     <= x_hold_d;
      beam_on_q    <= beam_on_d;
      line_open_q  <= line_open_d;
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_laser_vector_byte_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_laser_vector_byte_parser_core
// Self-checking bench for the laser vector byte parser. Whole files are fed
// in as byte requests: count, header, then x,y pairs with beam codes, repeated
// points, truncated files and stray bytes. A behavioral parser inside the
// bench predicts every point and line end. Results are compared in order as
// they leave the core. Four phases cover free flow, a slow sender, a stalling
// receiver, and both at once.
// ----------------------------------------------------------------------------

module tb_laser_vector_byte_parser_core;
  import lvbp_pkg::*;

  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned ItemsPerPhase = 500;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned EndLimit      = 4000;

  // Beam escape codes and nominal header bytes
  localparam logic [7:0] EscX     = 8'hFF;
  localparam logic [7:0] BeamOnY  = 8'hFF;
  localparam logic [7:0] BeamOffY = 8'hFE;
  localparam logic [7:0] HdrByte0 = 8'h00;
  localparam logic [7:0] HdrByte1 = 8'hC8;

  typedef enum logic [2:0] {
    StIdle, StCntHi, StHdrA, StHdrB, StPairX, StPairY, StDone
  } parse_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
  } file_byte_t;

  // Sender idle / receiver stall percentages per phase
  localparam int unsigned SrcIdle [NumPhases] = '{0, 54, 0, 21};
  localparam int unsigned SnkStall[NumPhases] = '{0, 0, 54, 21};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [23:0] m_axis_tdata;
  wire         m_axis_tuser;
  wire         m_axis_tlast;

  laser_vector_byte_parser_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tuser  (s_axis_tuser),   // [0] frame_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] point_x, [15:8] point_y, [16] first_in_line
    .m_axis_tuser  (m_axis_tuser),   // [0] kind
    .m_axis_tlast  (m_axis_tlast)    // last_of_run
  );

  // Stimulus and expected results
  file_byte_t  file_bytes_q[$];
  result_t     drawn_q[$];
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  bit          byte_taken    = 1'b0;

  // Bench copy of the parser state
  parse_state_e ps_state      = StIdle;
  logic [15:0]  ps_pairs_left = '0;
  logic [7:0]   ps_count_lo   = '0;
  logic [7:0]   ps_x_hold     = '0;
  logic [7:0]   ps_last_x     = '0;
  logic [7:0]   ps_last_y     = '0;
  logic         ps_beam_on    = 1'b0;
  logic         ps_line_open  = 1'b0;

  // Generator memory of the last point pair, for repeats
  logic [7:0] gen_last_x = '0;
  logic [7:0] gen_last_y = '0;

  int unsigned n_items     = 0;
  int unsigned n_bytes     = 0;
  int unsigned n_files     = 0;
  int unsigned n_points    = 0;
  int unsigned n_line_ends = 0;
  int unsigned n_double    = 0;
  int unsigned n_errors    = 0;

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic result_t point_res(logic [7:0] x, logic [7:0] y, logic first);
    point_res = '{kind: KindPoint, point_x: x, point_y: y, first_in_line: first,
                  last_of_run: 1'b0};
  endfunction

  // Parse one accepted byte and queue the results it must produce
  function automatic void parse_byte(logic [7:0] b, logic fs);
    result_t     res[2];
    int unsigned n;
    logic [16:0] cnt;
    logic [7:0]  y;
    n = 0;
    if (fs) begin
      // new file: close any open line, restart with beam off
      if (ps_line_open) begin
        res[n] = LineEndRes;
        n++;
      end
      ps_line_open = 1'b0;
      ps_beam_on   = 1'b0;
      ps_last_x    = '0;
      ps_last_y    = '0;
      ps_x_hold    = '0;
      ps_count_lo  = b;
      ps_state     = StCntHi;
      n_files++;
    end else begin
      case (ps_state)
        StCntHi: begin
          // pairs = ceil(count / 2), carried into bit 16
          cnt           = {1'b0, b, ps_count_lo} + 17'd1;
          ps_pairs_left = cnt[16:1];
          ps_state      = StHdrA;
        end
        StHdrA: ps_state = StHdrB;
        StHdrB: begin
          if (ps_pairs_left == '0) ps_state = StDone;
          else ps_state = StPairX;
        end
        StPairX: begin
          ps_x_hold = b;
          ps_state  = StPairY;
        end
        StPairY: begin
          if (ps_x_hold == EscX && (b == BeamOffY || b == BeamOnY)) begin
            ps_beam_on = (b == BeamOnY);
          end else begin
            y = 8'hFF - b;
            if (ps_beam_on) begin
              if (!ps_line_open) begin
                res[n] = point_res(ps_x_hold, y, 1'b1);
                n++;
                ps_line_open = 1'b1;
                ps_last_x    = ps_x_hold;
                ps_last_y    = y;
              end else if (ps_last_x != ps_x_hold || ps_last_y != y) begin
                // repeated point within a line is dropped
                res[n] = point_res(ps_x_hold, y, 1'b0);
                n++;
                ps_last_x = ps_x_hold;
                ps_last_y = y;
              end
            end else if (ps_line_open) begin
              res[n] = LineEndRes;
              n++;
              ps_line_open = 1'b0;
            end
          end
          ps_pairs_left = ps_pairs_left - 16'd1;
          if (ps_pairs_left == '0) begin
            if (ps_line_open) begin
              res[n] = LineEndRes;
              n++;
              ps_line_open = 1'b0;
            end
            ps_state = StDone;
          end else begin
            ps_state = StPairX;
          end
        end
        default: ;  // idle and done ignore bytes
      endcase
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    if (n == 2) n_double++;
    for (int i = 0; i < n; i++) begin
      if (res[i].kind == KindLineEnd) n_line_ends++;
      else n_points++;
      drawn_q.push_back(res[i]);
    end
  endfunction

  task automatic report_bad(string what, result_t want, result_t got);
    n_errors++;
    if (n_errors <= MaxReported)
      $display("[%0t] ERROR %s: expected kind=%0d x=%0d y=%0d first=%0d last=%0d, ",
               $time, what, want.kind, want.point_x, want.point_y, want.first_in_line,
               want.last_of_run,
               "got kind=%0d x=%0d y=%0d first=%0d last=%0d",
               got.kind, got.point_x, got.point_y, got.first_in_line, got.last_of_run);
  endtask

  // Request side: prediction on acceptance
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      parse_byte(s_axis_tdata, s_axis_tuser);
      void'(file_bytes_q.pop_front());
      byte_taken = 1'b1;
      n_bytes++;
    end
  end

  // Driver: new request or idle at the falling edge, random receiver stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || byte_taken) begin
        if (file_bytes_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= file_bytes_q[0].data;
          s_axis_tuser  <= file_bytes_q[0].fs;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      byte_taken = 1'b0;
      m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Monitor: compare each result request with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: m_axis_tuser, point_x: m_axis_tdata[7:0], point_y: m_axis_tdata[15:8],
              first_in_line: m_axis_tdata[16], last_of_run: m_axis_tlast};
      if (drawn_q.size() == 0) begin
        report_bad("result with nothing expected", '0, got);
      end else begin
        want = drawn_q.pop_front();
        if (got.kind !== want.kind || got.point_x !== want.point_x ||
            got.point_y !== want.point_y || got.first_in_line !== want.first_in_line ||
            got.last_of_run !== want.last_of_run || m_axis_tdata[23:17] !== '0)
          report_bad("result mismatch", want, got);
      end
    end
  end

  task automatic push_byte(logic [7:0] d, logic fs);
    file_bytes_q.push_back('{data: d, fs: fs});
    n_items++;
  endtask

  task automatic push_pair(logic [7:0] x, logic [7:0] yb);
    push_byte(x, 1'b0);
    push_byte(yb, 1'b0);
  endtask

  // One random file, sometimes cut short, sometimes followed by stray bytes
  task automatic push_file();
    file_byte_t  body[$];
    int unsigned count;
    int unsigned pairs;
    int unsigned cut;
    int unsigned r;
    int unsigned k;
    logic [7:0]  x;
    logic [7:0]  yb;
    r = $urandom_range(0, 99);
    if (r < 3) count = $urandom_range(16'hFF00, 16'hFFFF);  // huge, always cut short
    else if (r < 6) count = $urandom_range(256, 400);
    else if (r < 12) count = $urandom_range(0, 2);
    else count = $urandom_range(3, 48);
    body.push_back('{data: count[7:0], fs: 1'b1});
    body.push_back('{data: count[15:8], fs: 1'b0});
    if ($urandom_range(0, 4) == 0) begin
      body.push_back('{data: 8'($urandom), fs: 1'b0});
      body.push_back('{data: 8'($urandom), fs: 1'b0});
    end else begin
      body.push_back('{data: HdrByte0, fs: 1'b0});
      body.push_back('{data: HdrByte1, fs: 1'b0});
    end
    pairs = (count + 1) / 2;
    if (r < 3) pairs = $urandom_range(4, 30);
    for (int p = 0; p < pairs; p++) begin
      k = $urandom_range(0, 99);
      if (k < 14) begin
        x  = EscX;
        yb = BeamOnY;
      end else if (k < 22) begin
        x  = EscX;
        yb = BeamOffY;
      end else if (k < 34) begin
        x  = gen_last_x;
        yb = gen_last_y;
      end else begin
        x  = 8'($urandom);
        yb = 8'($urandom);
        if (k < 40) begin
          x  = EscX;
          yb = 8'($urandom_range(0, 253));
        end else if (k < 45) begin
          x  = 8'h00;
          yb = 8'hFF;
        end else if (k < 50) begin
          yb = 8'h00;
        end
        gen_last_x = x;
        gen_last_y = yb;
      end
      body.push_back('{data: x, fs: 1'b0});
      body.push_back('{data: yb, fs: 1'b0});
    end
    cut = body.size();
    if (r < 3 || $urandom_range(0, 9) == 0) cut = $urandom_range(1, body.size());
    for (int i = 0; i < cut; i++) push_byte(body[i].data, body[i].fs);
    // stray bytes after the file, ignored by the parser only if the file was complete
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) file_bytes_q.push_back('{data: 8'($urandom), fs: 1'b0});
  endtask

  task automatic wait_drained(int unsigned limit);
    int unsigned waited;
    waited = 0;
    while ((file_bytes_q.size() != 0 || drawn_q.size() != 0) && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NumPhases; ph++) begin
      src_idle_pct  = SrcIdle[ph];
      snk_stall_pct = SnkStall[ph];
      if (ph == 0) begin
        // stray byte before any file start
        push_byte(8'h5A, 1'b0);
        // count 5: beam on, corner point, repeat dropped, line closes at the end
        push_byte(8'd5, 1'b1);
        push_byte(8'd0, 1'b0);
        push_byte(HdrByte0, 1'b0);
        push_byte(HdrByte1, 1'b0);
        push_pair(EscX, BeamOnY);
        push_pair(8'h00, 8'hFF);
        push_pair(8'h00, 8'hFF);
        // byte after the count is used up
        push_byte(8'hA5, 1'b0);
        // empty file with odd header bytes
        push_byte(8'd0, 1'b1);
        push_byte(8'd0, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        // largest count: off closes nothing, point while off closes the line,
        // the line left open is closed by the next file start
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(HdrByte0, 1'b0);
        push_byte(HdrByte1, 1'b0);
        push_pair(EscX, BeamOnY);
        push_pair(8'h01, 8'h02);
        push_pair(EscX, BeamOffY);
        push_pair(8'h03, 8'h04);
        push_pair(EscX, BeamOnY);
        push_pair(EscX, 8'h00);
      end
      phase_start = n_items;
      while (n_items - phase_start < ItemsPerPhase) push_file();
      // sender holds off until every expected result has come back
      wait_drained(ph == NumPhases - 1 ? EndLimit : 32'hFFFF_FFFF);
    end

    while (drawn_q.size() != 0)
      report_bad("expected result never came", drawn_q.pop_front(), '0);
    if (file_bytes_q.size() != 0) begin
      n_errors++;
      if (n_errors <= MaxReported)
        $display("[%0t] ERROR %0d byte requests never accepted", $time, file_bytes_q.size());
    end

    $display("Run covered %0d files over %0d accepted bytes in %0d idling phases.",
             n_files, n_bytes, NumPhases);
    $display("Checked %0d points and %0d line ends, %0d bytes with two results, %0d errors.",
             n_points, n_line_ends, n_double, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(5_000_000);
    $display("Timeout: results still outstanding=%0d, bytes queued=%0d",
             drawn_q.size(), file_bytes_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ laser_vector_byte_parser_core.f @@
+incdir+src
src/lvbp_pkg.sv
src/lvbp_parser.sv
src/laser_vector_byte_parser_core.sv
verif/tb_laser_vector_byte_parser_core.sv
